>>> rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the commutator checkers.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held (active-low reset).
`define SSC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define SSC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> rtl/ssc_pkg.sv
// ---------------------------------------------------------------------------
// ssc_pkg
// Types, constants and commutation tables for the six-step start-up block.
// ---------------------------------------------------------------------------
package ssc_pkg;

  localparam int unsigned PERIOD_W = 16;
  localparam int unsigned RAMP_W   = 8;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned GATE_W   = 6;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 16;

  // Register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] CFG_START_PERIOD  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_PERIOD    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RAMP_INTERVAL = 2'd2;

  // Reset values
  localparam logic [PERIOD_W-1:0] RST_START_PERIOD  = 16'd1000;
  localparam logic [PERIOD_W-1:0] RST_MIN_PERIOD    = 16'd50;
  localparam logic [RAMP_W-1:0]   RST_RAMP_INTERVAL = 8'd200;

  localparam logic [STEP_W-1:0] STEP_FIRST = 3'd1;
  localparam logic [STEP_W-1:0] STEP_LAST  = 3'd6;
  localparam logic [STEP_W-1:0] STEP_WRAP  = 3'd7;

  // Gate bit positions inside the internal gate word
  localparam int unsigned G_HA = 5;
  localparam int unsigned G_LA = 4;
  localparam int unsigned G_HB = 3;
  localparam int unsigned G_LB = 2;
  localparam int unsigned G_HC = 1;
  localparam int unsigned G_LC = 0;

  localparam logic [GATE_W-1:0] GATES_OFF = 6'b000000;
  localparam logic [GATE_W-1:0] GATE_LOWS = 6'b010101;

  typedef struct packed {
    logic [GATE_W-1:0] gates;
    logic [STEP_W-1:0] step;
    logic              handoff;
  } status_t;

  // Commutation pattern, HA LA HB LB HC LC from the top bit down
  function automatic logic [GATE_W-1:0] pattern_of(input logic [STEP_W-1:0] s);
    logic [GATE_W-1:0] p;
    case (s)
      3'd1:    p = 6'b110100;
      3'd2:    p = 6'b110001;
      3'd3:    p = 6'b001101;
      3'd4:    p = 6'b011100;
      3'd5:    p = 6'b010011;
      3'd6:    p = 6'b000111;
      default: p = GATES_OFF;
    endcase
    return p;
  endfunction

  // Low-side gates chopped in each step
  function automatic logic [GATE_W-1:0] chop_of(input logic [STEP_W-1:0] s);
    logic [GATE_W-1:0] m;
    case (s)
      3'd1, 3'd4: m = 6'b010100;
      3'd2, 3'd5: m = 6'b010001;
      3'd3, 3'd6: m = 6'b000101;
      default:    m = GATES_OFF;
    endcase
    return m;
  endfunction

endpackage

>>> rtl/ssc_core.sv
// ---------------------------------------------------------------------------
// ssc_core
// Start-up state: ramp, chop and commutation counters, at most one tick per update.
// ---------------------------------------------------------------------------
module ssc_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  input  logic                             upd,
  input  logic                             tick,
  output ssc_pkg::status_t                 status_nxt
);

  logic [ssc_pkg::PERIOD_W-1:0] start_period_r, min_period_r;
  logic [ssc_pkg::RAMP_W-1:0]   ramp_interval_r;

  logic [ssc_pkg::PERIOD_W-1:0] elapsed_r, elapsed_nxt;
  logic [ssc_pkg::RAMP_W-1:0]   ramp_r, ramp_nxt;
  logic [ssc_pkg::PERIOD_W-1:0] period_r, period_nxt;
  logic                         handoff_r, handoff_nxt;
  logic [ssc_pkg::PERIOD_W-1:0] chop_r, chop_nxt;
  logic [ssc_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic [ssc_pkg::GATE_W-1:0]   gates_r, gates_nxt;

  logic [ssc_pkg::PERIOD_W-1:0] elapsed_inc, period_dec, chop_inc;
  logic [ssc_pkg::RAMP_W-1:0]   ramp_inc;
  logic [ssc_pkg::STEP_W-1:0]   step_inc;
  logic                         step_ok;
  logic [ssc_pkg::GATE_W-1:0]   gates_chop;

  always_comb begin
    elapsed_inc = elapsed_r + 16'd1;
    ramp_inc    = ramp_r + 8'd1;
    period_dec  = period_r - 16'd1;
    chop_inc    = chop_r + 16'd1;
    step_inc    = step_r + 3'd1;
    step_ok     = (step_r >= ssc_pkg::STEP_FIRST) && (step_r <= ssc_pkg::STEP_LAST);

    elapsed_nxt = elapsed_r;
    ramp_nxt    = ramp_r;
    period_nxt  = period_r;
    handoff_nxt = handoff_r;
    chop_nxt    = chop_r;
    step_nxt    = step_r;
    gates_nxt   = gates_r;
    gates_chop  = gates_r;

    if (tick) begin
      elapsed_nxt = elapsed_inc;
      ramp_nxt    = ramp_inc;

      // period ramp
      if (ramp_inc >= ramp_interval_r) begin
        ramp_nxt = '0;
        if (period_dec <= min_period_r) begin
          period_nxt  = min_period_r;
          handoff_nxt = 1'b1;
        end else begin
          period_nxt = period_dec;
        end
      end

      // low-side chopping, before any commutation in this tick
      if (handoff_nxt) begin
        chop_nxt = chop_inc;
        if (chop_inc >= (min_period_r >> 2)) begin
          chop_nxt = '0;
          if (step_ok) begin
            gates_chop = (gates_r & ~ssc_pkg::GATE_LOWS)
                       | (~gates_r & ssc_pkg::chop_of(step_r));
          end
        end
      end
      gates_nxt = gates_chop;

      // commutation
      if (elapsed_inc >= period_nxt) begin
        elapsed_nxt = '0;
        if (step_ok) begin
          gates_nxt = ssc_pkg::pattern_of(step_r);
          step_nxt  = (step_inc >= ssc_pkg::STEP_WRAP) ? ssc_pkg::STEP_FIRST : step_inc;
        end else begin
          step_nxt = ssc_pkg::STEP_FIRST;
        end
      end
    end

    status_nxt.gates   = gates_nxt;
    status_nxt.step    = step_nxt;
    status_nxt.handoff = handoff_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_period_r  <= ssc_pkg::RST_START_PERIOD;
      min_period_r    <= ssc_pkg::RST_MIN_PERIOD;
      ramp_interval_r <= ssc_pkg::RST_RAMP_INTERVAL;
      elapsed_r       <= '0;
      ramp_r          <= '0;
      period_r        <= ssc_pkg::RST_START_PERIOD;
      handoff_r       <= 1'b0;
      chop_r          <= '0;
      step_r          <= ssc_pkg::STEP_FIRST;
      gates_r         <= ssc_pkg::GATES_OFF;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssc_pkg::CFG_START_PERIOD: begin
          start_period_r <= cfg_wdata;
          period_r       <= cfg_wdata;
        end
        ssc_pkg::CFG_MIN_PERIOD:    min_period_r    <= cfg_wdata;
        ssc_pkg::CFG_RAMP_INTERVAL: ramp_interval_r <= cfg_wdata[ssc_pkg::RAMP_W-1:0];
        default: ;
      endcase
    end else if (upd) begin
      elapsed_r <= elapsed_nxt;
      ramp_r    <= ramp_nxt;
      period_r  <= period_nxt;
      handoff_r <= handoff_nxt;
      chop_r    <= chop_nxt;
      step_r    <= step_nxt;
      gates_r   <= gates_nxt;
    end
  end

endmodule

>>> rtl/six_step_startup_commutator_top.sv
// ---------------------------------------------------------------------------
// six_step_startup_commutator_top
// Open-loop six-step BLDC start-up: period ramp, commutation and chopping.
// ---------------------------------------------------------------------------
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  in_     | in  | tick (tdata[0])
//  out_    | out | gate drives, step_now, handed_off (see out_tdata)
//  cfg_    | in  | register write: 0 start_period, 1 min_period, 2 ramp_interval
//
//  One beat per clock sustained while out_tready stays high. A beat is taken
//  into the input register, is applied to the start-up state on leaving it,
//  and the result is held in the output register, which raises out_tvalid.
//  in_tready stays high while the output register is stalled only as long as
//  the input register is empty; the ready path is a short combinational chain.
//  rst_n (synchronous) clears both stages, all counters and the registers
//  to their reset values. Write configuration only with both stages empty.
// ---------------------------------------------------------------------------
module six_step_startup_commutator_top (
  input  logic                              clk,
  input  logic                              rst_n,
  // input stream
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [ssc_pkg::IN_DATA_W-1:0]     in_tdata,   // [0] tick, [7:1] zero
  // result stream
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [ssc_pkg::OUT_DATA_W-1:0]    out_tdata,  // [0] high_a [1] low_a
                                                        // [2] high_b [3] low_b
                                                        // [4] high_c [5] low_c
                                                        // [8:6] step_now
                                                        // [9] handed_off, [15:10] 0
  // configuration writes
  input  logic                              cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  logic             s1_valid_r;
  logic             s1_tick_r;
  logic             out_valid_r;
  ssc_pkg::status_t out_stat_r;
  ssc_pkg::status_t status_nxt;
  logic             adv;

  // stage 1 moves on whenever the output register is free or being drained
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;

  ssc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .upd        (adv),
    .tick       (s1_tick_r),
    .status_nxt (status_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv)                        out_valid_r <= 1'b1;
      else if (out_tready)            out_valid_r <= 1'b0;
    end
  end

  // payload, no reset needed
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) s1_tick_r  <= in_tdata[0];
    if (adv)                    out_stat_r <= status_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b000000,
                       out_stat_r.handoff,
                       out_stat_r.step,
                       out_stat_r.gates[ssc_pkg::G_LC],
                       out_stat_r.gates[ssc_pkg::G_HC],
                       out_stat_r.gates[ssc_pkg::G_LB],
                       out_stat_r.gates[ssc_pkg::G_HB],
                       out_stat_r.gates[ssc_pkg::G_LA],
                       out_stat_r.gates[ssc_pkg::G_HA]};

endmodule

>>> rtl/ssc_checker.sv
// ---------------------------------------------------------------------------
// ssc_checker
// Port-level checks on the commutator result stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ssc_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [ssc_pkg::OUT_DATA_W-1:0] out_tdata
);

  // stalled beat holds
  `SSC_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata), "stalled result beat changed")
  // handoff never drops once reported
  `SSC_ASSERT(a_handoff_sticky, clk, rst_n, out_tvalid && out_tdata[9] |=> !out_tvalid || out_tdata[9], "handed_off dropped")
  // step stays within one to six
  `SSC_ASSERT(a_step_range, clk, rst_n, out_tvalid |-> (out_tdata[8:6] == 3'd1 || out_tdata[8:6] == 3'd2 || out_tdata[8:6] == 3'd3 || out_tdata[8:6] == 3'd4 || out_tdata[8:6] == 3'd5 || out_tdata[8:6] == 3'd6), "step_now out of range")
  // reset empties the result register
  `SSC_ASSERT_ALWAYS(a_rst_empty, clk, !rst_n |=> !out_tvalid, "result valid after reset")

endmodule

bind six_step_startup_commutator_top ssc_checker u_ssc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

>>> tb/ssc_drive_checker.sv
// ----------------------------------------------------------------------------
// ssc_drive_checker
// Watches the tick, result and register-write channels of the six-step
// start-up commutator, keeps its own copy of the ramp, chop and commutation
// state, and compares every result beat with the predicted gate drive.
// ----------------------------------------------------------------------------
module ssc_drive_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [ssc_pkg::IN_DATA_W-1:0]  in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [ssc_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           cfg_we,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int unsigned                    fails,
  output int unsigned                    pending
);

  // out_tdata[9:0], lowest bit last in the list
  typedef struct packed {
    logic                       handoff;
    logic [ssc_pkg::STEP_W-1:0] step;
    logic                       lc;
    logic                       hc;
    logic                       lb;
    logic                       hb;
    logic                       la;
    logic                       ha;
  } drive_t;

  logic [ssc_pkg::PERIOD_W-1:0] min_reg;
  logic [ssc_pkg::RAMP_W-1:0]   ramp_reg;

  logic [ssc_pkg::PERIOD_W-1:0] elapsed;
  logic [ssc_pkg::RAMP_W-1:0]   ramp_cnt;
  logic [ssc_pkg::PERIOD_W-1:0] period;
  logic                         handed;
  logic [ssc_pkg::PERIOD_W-1:0] chop_cnt;
  logic [ssc_pkg::STEP_W-1:0]   step;
  logic [ssc_pkg::GATE_W-1:0]   gates;

  drive_t      expected_drive_q[$];
  int unsigned fail_tally = 0;

  assign fails = fail_tally;

  function automatic logic [ssc_pkg::GATE_W-1:0] step_pattern(
    input logic [ssc_pkg::STEP_W-1:0] s);
    logic [ssc_pkg::GATE_W-1:0] g;
    g = '0;
    case (s)
      3'd1: begin
        g[ssc_pkg::G_HA] = 1'b1; g[ssc_pkg::G_LA] = 1'b1; g[ssc_pkg::G_LB] = 1'b1;
      end
      3'd2: begin
        g[ssc_pkg::G_HA] = 1'b1; g[ssc_pkg::G_LA] = 1'b1; g[ssc_pkg::G_LC] = 1'b1;
      end
      3'd3: begin
        g[ssc_pkg::G_HB] = 1'b1; g[ssc_pkg::G_LB] = 1'b1; g[ssc_pkg::G_LC] = 1'b1;
      end
      3'd4: begin
        g[ssc_pkg::G_LA] = 1'b1; g[ssc_pkg::G_HB] = 1'b1; g[ssc_pkg::G_LB] = 1'b1;
      end
      3'd5: begin
        g[ssc_pkg::G_LA] = 1'b1; g[ssc_pkg::G_HC] = 1'b1; g[ssc_pkg::G_LC] = 1'b1;
      end
      3'd6: begin
        g[ssc_pkg::G_LB] = 1'b1; g[ssc_pkg::G_HC] = 1'b1; g[ssc_pkg::G_LC] = 1'b1;
      end
      default: g = '0;
    endcase
    return g;
  endfunction

  function automatic logic [ssc_pkg::GATE_W-1:0] chop_mask(
    input logic [ssc_pkg::STEP_W-1:0] s);
    logic [ssc_pkg::GATE_W-1:0] m;
    m = '0;
    case (s)
      3'd1, 3'd4: begin m[ssc_pkg::G_LA] = 1'b1; m[ssc_pkg::G_LB] = 1'b1; end
      3'd2, 3'd5: begin m[ssc_pkg::G_LA] = 1'b1; m[ssc_pkg::G_LC] = 1'b1; end
      3'd3, 3'd6: begin m[ssc_pkg::G_LB] = 1'b1; m[ssc_pkg::G_LC] = 1'b1; end
      default: m = '0;
    endcase
    return m;
  endfunction

  // one timer period: ramp, then chop, then commutation
  task automatic advance_one_tick();
    logic step_ok;
    step_ok = (step >= ssc_pkg::STEP_FIRST) && (step <= ssc_pkg::STEP_LAST);
    elapsed  = elapsed + 1'b1;
    ramp_cnt = ramp_cnt + 1'b1;
    if (ramp_cnt >= ramp_reg) begin
      period = period - 1'b1;
      if (period <= min_reg) begin
        period = min_reg;
        handed = 1'b1;
      end
      ramp_cnt = '0;
    end
    if (handed) begin
      chop_cnt = chop_cnt + 1'b1;
      if (chop_cnt >= (min_reg >> 2)) begin
        if (step_ok)
          gates = (gates & ~ssc_pkg::GATE_LOWS) | (~gates & chop_mask(step));
        chop_cnt = '0;
      end
    end
    if (elapsed >= period) begin
      elapsed = '0;
      if (step_ok) begin
        gates = step_pattern(step);
        step  = (step == ssc_pkg::STEP_LAST) ? ssc_pkg::STEP_FIRST : step + 1'b1;
      end else begin
        step = ssc_pkg::STEP_FIRST;
      end
    end
  endtask

  function automatic drive_t present_drive();
    drive_t d;
    d.ha      = gates[ssc_pkg::G_HA];
    d.la      = gates[ssc_pkg::G_LA];
    d.hb      = gates[ssc_pkg::G_HB];
    d.lb      = gates[ssc_pkg::G_LB];
    d.hc      = gates[ssc_pkg::G_HC];
    d.lc      = gates[ssc_pkg::G_LC];
    d.step    = step;
    d.handoff = handed;
    return d;
  endfunction

  task automatic log_fault(input string what, input drive_t want, input drive_t got);
    fail_tally++;
    if (fail_tally <= 10)
      $display({"%0t %s: exp ha%b la%b hb%b lb%b hc%b lc%b step%0d ho%b,",
                " got ha%b la%b hb%b lb%b hc%b lc%b step%0d ho%b"},
               $realtime, what,
               want.ha, want.la, want.hb, want.lb, want.hc, want.lc,
               want.step, want.handoff,
               got.ha, got.la, got.hb, got.lb, got.hc, got.lc,
               got.step, got.handoff);
  endtask

  always @(posedge clk) begin : watch
    drive_t got;
    drive_t want;
    if (!rst_n) begin
      min_reg  = ssc_pkg::RST_MIN_PERIOD;
      ramp_reg = ssc_pkg::RST_RAMP_INTERVAL;
      elapsed  = '0;
      ramp_cnt = '0;
      period   = ssc_pkg::RST_START_PERIOD;
      handed   = 1'b0;
      chop_cnt = '0;
      step     = ssc_pkg::STEP_FIRST;
      gates    = ssc_pkg::GATES_OFF;
      expected_drive_q.delete();
    end else begin
      // a result beat leaves only after passing the input and output registers
      if (out_tvalid && out_tready) begin
        got = drive_t'(out_tdata[9:0]);
        if (expected_drive_q.size() == 0) begin
          log_fault("unexpected beat", '0, got);
        end else begin
          want = expected_drive_q.pop_front();
          if (got.ha !== want.ha || got.la !== want.la || got.hb !== want.hb ||
              got.lb !== want.lb || got.hc !== want.hc || got.lc !== want.lc ||
              got.step !== want.step || got.handoff !== want.handoff)
            log_fault("mismatch", want, got);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          ssc_pkg::CFG_START_PERIOD:  period   = cfg_wdata;
          ssc_pkg::CFG_MIN_PERIOD:    min_reg  = cfg_wdata;
          ssc_pkg::CFG_RAMP_INTERVAL: ramp_reg = cfg_wdata[ssc_pkg::RAMP_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready) begin
        if (in_tdata[0])
          advance_one_tick();
        expected_drive_q.push_back(present_drive());
      end
    end
    pending <= expected_drive_q.size();
  end

endmodule

>>> tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the six-step start-up commutator: a directed
// sweep of the corner settings, then randomised tick streams under several
// register settings, with bursty input, a wandering output stall and one
// long output hold-off. Checking lives in ssc_drive_checker.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int unsigned QUIET_LIMIT = 5000;  // cycles with no beat at all
  localparam int unsigned HOLD_CYCLES = 80;    // long output hold-off
  localparam int unsigned TAIL_CYCLES = 4;     // beyond the two-stage pipeline

  // index with no register behind it; a write there must change nothing
  localparam logic [ssc_pkg::CFG_IDX_W-1:0] CFG_NO_REG = 2'd3;

  // output-side stall behaviours
  typedef enum int unsigned {RX_OPEN, RX_COIN, RX_PATTERN, RX_STARVED} rx_mode_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [ssc_pkg::IN_DATA_W-1:0]  in_tdata = '0;    // [0] tick, rest zero
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [ssc_pkg::OUT_DATA_W-1:0] out_tdata;  // [0] ha [1] la [2] hb [3] lb
                                              // [4] hc [5] lc
                                              // [8:6] step_now [9] handed_off
  logic                           cfg_we = 1'b0;
  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  int unsigned fails;
  int unsigned pending;

  logic hold_req = 1'b0;  // asks the receiver for its long hold-off

  always #10 clk = ~clk;

  six_step_startup_commutator_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  ssc_drive_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fails      (fails),
    .pending    (pending)
  );

  // --------------------------------------------------------------------------
  // Receiver: segments of random length, each with its own stall behaviour.
  // Once hold_req is seen it refuses beats while hold_left counts down from
  // HOLD_CYCLES; both stages fill and in_tready drops while the sender offers.
  // --------------------------------------------------------------------------
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;
  int unsigned seg_left = 0;
  rx_mode_e    seg_mode = RX_OPEN;
  logic [2:0]  rx_phase = '0;

  always @(posedge clk) begin
    rx_phase <= rx_phase + 1'b1;
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      hold_left  <= HOLD_CYCLES;
      hold_done  <= 1'b1;
      out_tready <= 1'b0;
    end else begin
      if (seg_left == 0) begin
        seg_mode <= rx_mode_e'($urandom_range(0, 3));
        seg_left <= $urandom_range(10, 150);
      end else begin
        seg_left <= seg_left - 1;
      end
      case (seg_mode)
        RX_OPEN:    out_tready <= 1'b1;
        RX_COIN:    out_tready <= ($urandom_range(0, 1) == 1);
        RX_PATTERN: out_tready <= (rx_phase[1:0] != 2'b11);
        default:    out_tready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: a hang shows as a long stretch with no beat on either stream.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender helpers. Every task starts and ends just after a rising edge, so
  // each input gets at most one nonblocking update per time step.
  // --------------------------------------------------------------------------

  // offer one tick beat and hold it until taken
  task automatic send_tick(input logic tick_bit);
    in_tvalid <= 1'b1;
    in_tdata  <= {{(ssc_pkg::IN_DATA_W-1){1'b0}}, tick_bit};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every predicted result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [ssc_pkg::CFG_IDX_W-1:0]  idx,
                           input logic [ssc_pkg::CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // all three registers; only while both stages are empty
  task automatic set_regs(input logic [ssc_pkg::PERIOD_W-1:0]   start_p,
                          input logic [ssc_pkg::PERIOD_W-1:0]   min_p,
                          input logic [ssc_pkg::CFG_DATA_W-1:0] ramp_word);
    cfg_write(ssc_pkg::CFG_START_PERIOD, start_p);
    cfg_write(ssc_pkg::CFG_MIN_PERIOD, min_p);
    cfg_write(ssc_pkg::CFG_RAMP_INTERVAL, ramp_word);
    cfg_we <= 1'b0;
  endtask

  // random ticks (mostly live) in bursts; dense runs leave no gaps
  task automatic tick_stream(input int unsigned count, input bit dense);
    int unsigned burst;
    int unsigned gap;
    burst = 0;
    for (int unsigned k = 0; k < count; k++) begin
      if (burst == 0) begin
        burst = $urandom_range(1, 40);
        gap   = dense ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      send_tick($urandom_range(0, 99) < 85);
      burst--;
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : stimulus
    int unsigned lo;
    logic [7:0]  upper;
    logic [7:0]  rint;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values: an idle tick reports gates off, step 1, no handoff
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // zero start period wraps to the top on the first reduction; ramp
    // interval zero (upper byte of the write must be dropped) reduces every tick
    set_regs(16'd0, 16'd1, 16'hFF00);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    drain();

    // short ramp: one commutation before handoff, then handoff by ramping down
    set_regs(16'd4, 16'd1, 16'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();

    // start below the minimum: first reduction clamps and hands off;
    // chop interval of one, so every live tick chops
    set_regs(16'd3, 16'd5, 16'd1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();

    // write to the unused index must be ignored; all-ones extremes
    cfg_write(CFG_NO_REG, 16'h0007);
    set_regs(16'hFFFF, 16'hFFFF, 16'h00FF);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    drain();

    // minimum below four: chop on every tick once handed off
    set_regs(16'd6, 16'd2, 16'd0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b0);
    send_tick(1'b1);
    send_tick(1'b1);
    send_tick(1'b1);
    drain();

    // random part; each drain is the sender waiting for every result
    set_regs(16'd40, 16'd6, 16'd2);
    tick_stream(170, 1'b1);
    drain();

    for (int p = 0; p < 4; p++) begin
      lo    = $urandom_range(1, 24);
      upper = 8'($urandom_range(0, 255));
      rint  = 8'($urandom_range(0, 6));
      set_regs(16'(lo + $urandom_range(0, 40)), 16'(lo), {upper, rint});
      tick_stream(130, p[0]);
      drain();
    end

    // short minimum with the period starting near or below it
    lo    = $urandom_range(1, 3);
    upper = 8'($urandom_range(0, 255));
    rint  = 8'($urandom_range(0, 1));
    set_regs(16'($urandom_range(0, 12)), 16'(lo), {upper, rint});
    tick_stream(150, 1'b0);
    drain();

    // long output hold-off while ticks keep coming
    lo    = $urandom_range(30, 60);
    upper = 8'($urandom_range(0, 255));
    rint  = 8'($urandom_range(0, 255));
    set_regs(16'(lo + $urandom_range(0, 100)), 16'(lo), {upper, rint});
    hold_req <= 1'b1;
    tick_stream(180, 1'b0);
    drain();

    // smallest period and longest ramp interval
    set_regs(16'd1, 16'd1, 16'h00FF);
    tick_stream(100, 1'b1);
    drain();

    // allow any stray beat time to show up
    repeat (TAIL_CYCLES) @(posedge clk);

    if (fails == 0 && pending == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/ssc_pkg.sv
rtl/ssc_core.sv
rtl/six_step_startup_commutator_top.sv
rtl/ssc_checker.sv
tb/ssc_drive_checker.sv
tb/tb_top.sv
